>>> src/frq_pkg.sv
// Shared types and constants for the FIFO run queue scheduler.
// No dependencies; every other file of the block imports this package.
package frq_pkg;

   localparam int FRQ_MAX_TASKS = 64;
   localparam int TASK_W        = 6;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_REMOVE = 2'd1,
      OP_PICK   = 2'd2,
      OP_STATUS = 2'd3
   } req_op_type;

   // Field write enables of one task-table entry.
   typedef struct packed {
      logic queued;
      logic runnable;
      logic next;
      logic prev;
   } mem_wen_type;

endpackage

>>> src/frq_if.sv
// Valid/ready channel interfaces for requests and responses of the run queue.
// Depends on frq_pkg for the request code and field widths.
interface frq_req_if import frq_pkg::*; ();
   logic                valid;
   logic                ready;
   req_op_type          req_type;
   logic [TASK_W-1:0]   task_id;
   logic                runnable_value;

   modport source (output valid, req_type, task_id, runnable_value, input ready);
   modport sink   (input valid, req_type, task_id, runnable_value, output ready);
endinterface

interface frq_rsp_if import frq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                found;
   logic [TASK_W-1:0]   picked_task;
   logic                changed;

   modport source (output valid, found, picked_task, changed, input ready);
   modport sink   (input valid, found, picked_task, changed, output ready);
endinterface

>>> src/frq_mem.sv
// Task table memory: queued flag, runnable flag and both links per task.
// One write port with field enables, one read port with registered data.
module frq_mem import frq_pkg::*; #(
   parameter int MAX_TASKS = FRQ_MAX_TASKS
) (
   input  logic                               clock,
   input  mem_wen_type                        wen,
   input  logic [$clog2(MAX_TASKS)-1:0]       wr_addr,
   input  logic                               wr_queued,
   input  logic                               wr_runnable,
   input  logic [$clog2(MAX_TASKS+1)-1:0]     wr_next,
   input  logic [$clog2(MAX_TASKS+1)-1:0]     wr_prev,
   input  logic                               rd_en,
   input  logic [$clog2(MAX_TASKS)-1:0]       rd_addr,
   output logic                               rd_queued,
   output logic                               rd_runnable,
   output logic [$clog2(MAX_TASKS+1)-1:0]     rd_next,
   output logic [$clog2(MAX_TASKS+1)-1:0]     rd_prev
);

   localparam int LW = $clog2(MAX_TASKS + 1);
   localparam int EW = 2 * LW + 2;

   // Entry layout: queued, runnable, next link, prev link.
   logic [EW-1:0] mem [MAX_TASKS];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wen.queued) begin
         mem[wr_addr][2*LW+1] <= wr_queued;
      end
      if (wen.runnable) begin
         mem[wr_addr][2*LW] <= wr_runnable;
      end
      if (wen.next) begin
         mem[wr_addr][2*LW-1:LW] <= wr_next;
      end
      if (wen.prev) begin
         mem[wr_addr][LW-1:0] <= wr_prev;
      end
   end

   // Read data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_queued   = rd_data_ff[2*LW+1];
   assign rd_runnable = rd_data_ff[2*LW];
   assign rd_next     = rd_data_ff[2*LW-1:LW];
   assign rd_prev     = rd_data_ff[LW-1:0];

endmodule

>>> src/frq_ctrl.sv
// Request sequencer of the run queue: clear pass, list walk, link updates.
// Depends on frq_pkg and frq_if; drives the task table in frq_mem.
module frq_ctrl import frq_pkg::*; #(
   parameter int MAX_TASKS = FRQ_MAX_TASKS
) (
   input  logic                               clock,
   input  logic                               reset,
   frq_req_if.sink                            req_chan,
   frq_rsp_if.source                          rsp_chan,
   output mem_wen_type                        mem_wen,
   output logic [$clog2(MAX_TASKS)-1:0]       mem_wr_addr,
   output logic                               mem_wr_queued,
   output logic                               mem_wr_runnable,
   output logic [$clog2(MAX_TASKS+1)-1:0]     mem_wr_next,
   output logic [$clog2(MAX_TASKS+1)-1:0]     mem_wr_prev,
   output logic                               mem_rd_en,
   output logic [$clog2(MAX_TASKS)-1:0]       mem_rd_addr,
   input  logic                               mem_rd_queued,
   input  logic                               mem_rd_runnable,
   input  logic [$clog2(MAX_TASKS+1)-1:0]     mem_rd_next,
   input  logic [$clog2(MAX_TASKS+1)-1:0]     mem_rd_prev
);

   localparam int AW = $clog2(MAX_TASKS);
   localparam int LW = $clog2(MAX_TASKS + 1);
   localparam logic [LW-1:0] LINK_NULL = LW'(MAX_TASKS);
   localparam logic [AW-1:0] LAST_IDX  = AW'(MAX_TASKS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DISPATCH,
      ST_LOOK,
      ST_LINK_TAIL,
      ST_UNLINK_PREV,
      ST_UNLINK_NEXT,
      ST_RESULT
   } state_type;

   state_type           state_ff, state_in;
   req_op_type          op_ff, op_in;
   logic [TASK_W-1:0]   task_ff, task_in;
   logic                rv_ff, rv_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [LW-1:0]       vis_ff, vis_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [LW-1:0]       head_ff, head_in;
   logic [LW-1:0]       tail_ff, tail_in;
   logic                res_found_ff, res_found_in;
   logic                res_changed_ff, res_changed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [TASK_W-1:0]   rsp_picked_ff, rsp_picked_in;
   logic                rsp_changed_ff, rsp_changed_in;

   logic                task_ok;
   logic [AW-1:0]       task_idx;
   logic                req_fire;
   logic                rsp_take;

   assign task_ok  = 32'(task_ff) < 32'(MAX_TASKS);
   assign task_idx = AW'(task_ff);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_take = rsp_valid_ff && rsp_chan.ready;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      task_in        = task_ff;
      rv_in          = rv_ff;
      cur_in         = cur_ff;
      vis_in         = vis_ff;
      clr_in         = clr_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      res_found_in   = res_found_ff;
      res_changed_in = res_changed_ff;
      rsp_valid_in   = rsp_take ? 1'b0 : rsp_valid_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_picked_in  = rsp_picked_ff;
      rsp_changed_in = rsp_changed_ff;

      mem_wen         = '0;
      mem_wr_addr     = cur_ff;
      mem_wr_queued   = 1'b0;
      mem_wr_runnable = 1'b0;
      mem_wr_next     = LINK_NULL;
      mem_wr_prev     = LINK_NULL;
      mem_rd_en       = 1'b0;
      mem_rd_addr     = cur_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_addr      = clr_ff;
            mem_wen.queued   = 1'b1;
            mem_wen.runnable = 1'b1;
            clr_in           = clr_ff + AW'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_fire) begin
               op_in    = req_chan.req_type;
               task_in  = req_chan.task_id;
               rv_in    = req_chan.runnable_value;
               state_in = ST_DISPATCH;
            end
         end

         ST_DISPATCH: begin
            res_found_in   = 1'b0;
            res_changed_in = 1'b0;
            state_in       = ST_RESULT;
            unique case (op_ff)
               OP_PUSH, OP_REMOVE: begin
                  if (task_ok) begin
                     cur_in      = task_idx;
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = task_idx;
                     state_in    = ST_LOOK;
                  end
               end
               OP_STATUS: begin
                  if (task_ok) begin
                     mem_wen.runnable = 1'b1;
                     mem_wr_addr      = task_idx;
                     mem_wr_runnable  = rv_ff;
                  end
               end
               OP_PICK: begin
                  if (head_ff < LINK_NULL) begin
                     cur_in      = AW'(head_ff);
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = AW'(head_ff);
                     vis_in      = LW'(1);
                     state_in    = ST_LOOK;
                  end
               end
               default: ;
            endcase
         end

         ST_LOOK: begin
            state_in = ST_RESULT;
            unique case (op_ff)
               OP_PUSH: begin
                  if (!mem_rd_queued) begin
                     mem_wen.queued = 1'b1;
                     mem_wen.next   = 1'b1;
                     mem_wen.prev   = 1'b1;
                     mem_wr_queued  = 1'b1;
                     mem_wr_next    = LINK_NULL;
                     mem_wr_prev    = tail_ff;
                     state_in       = ST_LINK_TAIL;
                  end
               end
               OP_REMOVE: begin
                  if (mem_rd_queued) begin
                     mem_wen.queued = 1'b1;
                     state_in       = ST_UNLINK_PREV;
                  end
               end
               OP_PICK: begin
                  if (mem_rd_runnable) begin
                     // Dequeue and mark running in one write.
                     mem_wen.queued   = 1'b1;
                     mem_wen.runnable = 1'b1;
                     state_in         = ST_UNLINK_PREV;
                  end else if (mem_rd_next < LINK_NULL && vis_ff != LINK_NULL) begin
                     cur_in      = AW'(mem_rd_next);
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = AW'(mem_rd_next);
                     vis_in      = vis_ff + LW'(1);
                     state_in    = ST_LOOK;
                  end
               end
               default: ;
            endcase
         end

         ST_LINK_TAIL: begin
            if (tail_ff < LINK_NULL) begin
               mem_wen.next = 1'b1;
               mem_wr_addr  = AW'(tail_ff);
               mem_wr_next  = LW'(cur_ff);
            end else begin
               head_in = LW'(cur_ff);
            end
            tail_in        = LW'(cur_ff);
            res_changed_in = 1'b1;
            state_in       = ST_RESULT;
         end

         // The links of the removed entry stay on the read port from the lookup.
         ST_UNLINK_PREV: begin
            if (mem_rd_prev < LINK_NULL) begin
               mem_wen.next = 1'b1;
               mem_wr_addr  = AW'(mem_rd_prev);
               mem_wr_next  = mem_rd_next;
            end else begin
               head_in = (mem_rd_next < LINK_NULL) ? mem_rd_next : LINK_NULL;
            end
            state_in = ST_UNLINK_NEXT;
         end

         ST_UNLINK_NEXT: begin
            if (mem_rd_next < LINK_NULL) begin
               mem_wen.prev = 1'b1;
               mem_wr_addr  = AW'(mem_rd_next);
               mem_wr_prev  = mem_rd_prev;
            end else begin
               tail_in = (mem_rd_prev < LINK_NULL) ? mem_rd_prev : LINK_NULL;
            end
            if (op_ff == OP_PICK) begin
               res_found_in = 1'b1;
            end else begin
               res_changed_in = 1'b1;
            end
            state_in = ST_RESULT;
         end

         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_take) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = res_found_ff;
               rsp_picked_in  = res_found_ff ? TASK_W'(cur_ff) : '0;
               rsp_changed_in = res_changed_ff;
               state_in       = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         head_ff      <= LINK_NULL;
         tail_ff      <= LINK_NULL;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      task_ff        <= task_in;
      rv_ff          <= rv_in;
      cur_ff         <= cur_in;
      vis_ff         <= vis_in;
      res_found_ff   <= res_found_in;
      res_changed_ff <= res_changed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_picked_ff  <= rsp_picked_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.picked_task = rsp_picked_ff;
   assign rsp_chan.changed     = rsp_changed_ff;

endmodule

>>> src/fifo_run_queue_scheduler.sv
// Top level of the FIFO run queue scheduler: sequencer plus task table memory.
// Depends on frq_pkg, frq_if, frq_mem and frq_ctrl.
//
//   Channel    Direction  Transfer carries
//   req_chan   in         req_type, task_id, runnable_value
//   rsp_chan   out        found, picked_task, changed (one per request)
//
// A request is taken only while the sequencer is idle. A status request writes
// the runnable flag; a push or remove first looks up the task entry. A push
// that appends links the entry behind the tail; a remove or a pick that
// dequeues unlinks it from its neighbours. A pick walks the queue from the head
// until it finds a runnable entry or reaches the end. The single task table
// memory serves one read or one write per cycle, with registered read data. After
// reset a clearing pass zeroes the queued and runnable flags of every entry; no
// request is taken during it. A finished response waits in an output register,
// so the next request is taken while the response is stalled.
module fifo_run_queue_scheduler import frq_pkg::*; #(
   parameter int MAX_TASKS = FRQ_MAX_TASKS
) (
   input  logic        clock,
   input  logic        reset,
   frq_req_if.sink     req_chan,
   frq_rsp_if.source   rsp_chan
);

   localparam int AW = $clog2(MAX_TASKS);
   localparam int LW = $clog2(MAX_TASKS + 1);

   mem_wen_type   mem_wen;
   logic [AW-1:0] mem_wr_addr;
   logic          mem_wr_queued;
   logic          mem_wr_runnable;
   logic [LW-1:0] mem_wr_next;
   logic [LW-1:0] mem_wr_prev;
   logic          mem_rd_en;
   logic [AW-1:0] mem_rd_addr;
   logic          mem_rd_queued;
   logic          mem_rd_runnable;
   logic [LW-1:0] mem_rd_next;
   logic [LW-1:0] mem_rd_prev;

   // The sequencer handles one request at a time and owns head, tail and
   // the response register.
   frq_ctrl #(
      .MAX_TASKS (MAX_TASKS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .mem_wen         (mem_wen),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_queued   (mem_wr_queued),
      .mem_wr_runnable (mem_wr_runnable),
      .mem_wr_next     (mem_wr_next),
      .mem_wr_prev     (mem_wr_prev),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_queued   (mem_rd_queued),
      .mem_rd_runnable (mem_rd_runnable),
      .mem_rd_next     (mem_rd_next),
      .mem_rd_prev     (mem_rd_prev)
   );

   // Per-task flags and doubly linked list links.
   frq_mem #(
      .MAX_TASKS (MAX_TASKS)
   ) u_mem (
      .clock       (clock),
      .wen         (mem_wen),
      .wr_addr     (mem_wr_addr),
      .wr_queued   (mem_wr_queued),
      .wr_runnable (mem_wr_runnable),
      .wr_next     (mem_wr_next),
      .wr_prev     (mem_wr_prev),
      .rd_en       (mem_rd_en),
      .rd_addr     (mem_rd_addr),
      .rd_queued   (mem_rd_queued),
      .rd_runnable (mem_rd_runnable),
      .rd_next     (mem_rd_next),
      .rd_prev     (mem_rd_prev)
   );

   // The clearing pass keeps requests out right after reset.
   a_clear_blocks_req: assert property (@(posedge clock)
      reset |=> !req_chan.ready)
      else $error("request port ready during clearing pass");

   // The sequencer never reads and writes the table in the same cycle, so a
   // lookup can never see a half-finished update.
   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_rd_en && (mem_wen != '0)))
      else $error("task table read and write in the same cycle");

   // One request at a time: a transfer closes the request port.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request taken while one is in progress");

   // A pick result never reports a membership change, and an empty pick names task 0.
   a_rsp_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.found && rsp_chan.changed)
                         && (rsp_chan.found || rsp_chan.picked_task == '0))
      else $error("inconsistent response fields");

endmodule
